FILE: rtl/aho_corasick_matcher_defines.svh
// Assertion macros shared by the matcher's RTL files.
`ifndef AHO_CORASICK_MATCHER_DEFINES_SVH
`define AHO_CORASICK_MATCHER_DEFINES_SVH
`ifndef SYNTHESIS
`define ACM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("acm assertion failed");
`define ACM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("acm assertion failed");
`else
`define ACM_ASSERT(lbl, prop)
`define ACM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/acm_pkg.sv
// Types, constants and state codes of the multi-pattern matcher.
package acm_pkg;
    localparam int MAX_NODES       = 256;
    localparam int ALPHABET        = 128;
    localparam int MAX_PATTERNS    = 256;
    localparam int MAX_PATTERN_LEN = 32;
    localparam int POS_W           = 32;
    localparam int RES_CAP         = 32;
    localparam int QDEPTH          = 2;

    localparam int NODE_W   = $clog2(MAX_NODES);
    localparam int CNT_W    = $clog2(MAX_NODES + 1);
    localparam int PCNT_W   = $clog2(MAX_PATTERNS + 1);
    localparam int LEN_W    = $clog2(MAX_PATTERN_LEN + 1);
    localparam int ASYM_W   = $clog2(ALPHABET);
    localparam int CHILD_AW = NODE_W + ASYM_W;
    localparam int CHILD_D  = MAX_NODES * ALPHABET;
    localparam int RES_W    = $clog2(RES_CAP);
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_LONG    = 2'd2;
    localparam logic [1:0] ST_UNBUILT = 2'd3;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_BUILD = 2'd1,
        OP_SCAN  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0] action;
        logic [6:0] symbol;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic        match_found;
        logic [7:0]  pattern_id;
        logic [31:0] start_pos;
        logic [31:0] end_pos;
        logic        last_result;
    } t_out_item;

    typedef struct packed {
        t_op               op;
        logic [ASYM_W-1:0] symbol;
        logic              last;
    } t_cmd;

    typedef enum logic [4:0] {
        S_WIPE, S_IDLE,
        S_INS_RD, S_INS_CHK, S_INS_END,
        S_BLD_RD, S_BLD_CHK, S_BLD_G, S_BLD_GCHK, S_BLD_F, S_BLD_W, S_BLD_END,
        S_SCN_CH, S_SCN_CHK, S_SCN_F, S_SCN_N, S_SCN_N2, S_SCN_E, S_SCN_E2,
        S_CLR_RD, S_CLR_WR, S_CLR_END,
        S_EMIT
    } t_bstate;
endpackage

FILE: rtl/acm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module acm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: rtl/acm_front.sv
// Front end: accepts input transactions, decodes the action and queues commands.
`include "aho_corasick_matcher_defines.svh"
module acm_front import acm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_item i_in_item,
    output logic     o_in_stall,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_cmd_pop
);
    t_cmd              r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wp, n_wp, r_rp, n_rp;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              push;
    t_cmd              cmd_in;

    assign o_in_stall  = !i_rst_n || (r_cnt == QCNT_W'(QDEPTH));
    assign push        = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        cmd_in.symbol = i_in_item.symbol[ASYM_W-1:0];
        cmd_in.last   = i_in_item.last;
        cmd_in.op     = t_op'(i_in_item.action);
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push) begin
            n_wp = (r_wp == QPTR_W'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_cmd_pop) begin
            n_rp = (r_rp == QPTR_W'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (push && !i_cmd_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!push && i_cmd_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

    `ACM_ASSERT(a_pop_nonempty, i_cmd_pop |-> r_cnt != '0)
endmodule

FILE: rtl/acm_back.sv
// Back end: trie insert, failure-link build, text scan and clear sequencer.
`include "aho_corasick_matcher_defines.svh"
module acm_back import acm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    output logic      o_res_valid,
    output t_out_item o_res,
    input  logic      i_res_stall
);
    t_bstate             r_state, n_state;
    logic [CHILD_AW-1:0] r_wipe, n_wipe;
    logic [ASYM_W-1:0]   r_sym, n_sym, r_a, n_a;
    logic                r_last, n_last;
    logic [CNT_W-1:0]    r_node_count, n_node_count, r_c, n_c;
    logic [PCNT_W-1:0]   r_pcount, n_pcount;
    logic [NODE_W-1:0]   r_ins_node, n_ins_node;
    logic [LEN_W-1:0]    r_ins_len, n_ins_len, r_max_depth, n_max_depth, r_d, n_d;
    logic [1:0]          r_rej, n_rej, r_st, n_st;
    logic [NODE_W-1:0]   r_scan_node, n_scan_node, r_s, n_s, r_n, n_n;
    logic [NODE_W-1:0]   r_g, n_g, r_f, n_f;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic                r_built, n_built;
    logic [RES_W-1:0]    r_k, n_k;
    logic                r_ov;
    t_out_item           r_od;

    logic                ch_we;
    logic [CHILD_AW-1:0] ch_waddr, ch_raddr;
    logic [NODE_W-1:0]   ch_wdata, ch_rdata;
    logic                fl_we, ol_we, np_we, nd_we;
    logic [NODE_W-1:0]   fl_raddr, ol_raddr, np_raddr, nd_raddr, pa_raddr;
    logic [NODE_W-1:0]   fl_wdata, fl_rdata, ol_wdata, ol_rdata, pa_rdata;
    logic [PCNT_W-1:0]   np_wdata, np_rdata;
    logic [LEN_W-1:0]    nd_wdata, nd_rdata;
    logic [ASYM_W-1:0]   sy_rdata;
    logic [NODE_W-1:0]   nw_addr, lk_waddr, new_node;
    logic                em_valid, out_free, bld_last_c, bld_last_d, fin;
    t_out_item           em;

    assign out_free   = !r_ov || !i_res_stall;
    assign bld_last_c = (r_c == r_node_count - CNT_W'(1));
    assign bld_last_d = (r_d >= r_max_depth);
    assign new_node   = (ch_rdata == '0) ? r_node_count[NODE_W-1:0] : ch_rdata;
    assign fin        = (ol_rdata == '0) || (r_k == RES_W'(RES_CAP - 1));
    assign pa_raddr   = r_c[NODE_W-1:0];
    assign nw_addr    = new_node;
    assign lk_waddr   = r_c[NODE_W-1:0];

    acm_ram #(.WIDTH(NODE_W), .DEPTH(CHILD_D)) u_child (
        .i_clk, .i_we(ch_we), .i_waddr(ch_waddr), .i_wdata(ch_wdata),
        .i_raddr(ch_raddr), .o_rdata(ch_rdata));
    acm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_fail (
        .i_clk, .i_we(fl_we), .i_waddr(lk_waddr), .i_wdata(fl_wdata),
        .i_raddr(fl_raddr), .o_rdata(fl_rdata));
    acm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_olink (
        .i_clk, .i_we(ol_we), .i_waddr(lk_waddr), .i_wdata(ol_wdata),
        .i_raddr(ol_raddr), .o_rdata(ol_rdata));
    acm_ram #(.WIDTH(PCNT_W), .DEPTH(MAX_NODES)) u_pat (
        .i_clk, .i_we(np_we), .i_waddr(nw_addr), .i_wdata(np_wdata),
        .i_raddr(np_raddr), .o_rdata(np_rdata));
    acm_ram #(.WIDTH(LEN_W), .DEPTH(MAX_NODES)) u_depth (
        .i_clk, .i_we(nd_we), .i_waddr(nw_addr), .i_wdata(nd_wdata),
        .i_raddr(nd_raddr), .o_rdata(nd_rdata));
    acm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_parent (
        .i_clk, .i_we(nd_we), .i_waddr(nw_addr), .i_wdata(r_ins_node),
        .i_raddr(pa_raddr), .o_rdata(pa_rdata));
    acm_ram #(.WIDTH(ASYM_W), .DEPTH(MAX_NODES)) u_sym (
        .i_clk, .i_we(nd_we), .i_waddr(nw_addr), .i_wdata(r_sym),
        .i_raddr(pa_raddr), .o_rdata(sy_rdata));

    always_comb begin
        n_state = r_state;  n_wipe = r_wipe;  n_sym = r_sym;  n_a = r_a;
        n_last = r_last;  n_node_count = r_node_count;  n_c = r_c;
        n_pcount = r_pcount;  n_ins_node = r_ins_node;  n_ins_len = r_ins_len;
        n_max_depth = r_max_depth;  n_d = r_d;  n_rej = r_rej;  n_st = r_st;
        n_scan_node = r_scan_node;  n_s = r_s;  n_n = r_n;  n_g = r_g;  n_f = r_f;
        n_pos = r_pos;  n_built = r_built;  n_k = r_k;
        o_cmd_pop = 1'b0;
        ch_we = 1'b0;  ch_waddr = {r_ins_node, r_sym};  ch_wdata = '0;
        ch_raddr = {r_s, r_sym};
        fl_we = 1'b0;  ol_we = 1'b0;  np_we = 1'b0;  nd_we = 1'b0;
        fl_wdata = r_f;
        ol_wdata = '0;
        np_wdata = r_last ? r_pcount + 1'b1 : '0;
        nd_wdata = r_ins_len + 1'b1;
        fl_raddr = r_s;
        np_raddr = r_f;  ol_raddr = r_f;  nd_raddr = r_c[NODE_W-1:0];
        em_valid = 1'b0;
        em = '0;

        unique case (r_state)
            S_WIPE: begin
                ch_we    = 1'b1;
                ch_waddr = r_wipe;
                n_wipe   = r_wipe + 1'b1;
                if (r_wipe == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_sym     = i_cmd.symbol;
                    n_last    = i_cmd.last;
                    unique case (i_cmd.op)
                        OP_ADD: begin
                            n_built = 1'b0;
                            if (r_rej != ST_OK) begin
                                n_state = S_INS_END;
                            end else if (r_ins_len == '0 &&
                                         r_pcount >= PCNT_W'(MAX_PATTERNS)) begin
                                n_rej   = ST_FULL;
                                n_state = S_INS_END;
                            end else if (r_ins_len >= LEN_W'(MAX_PATTERN_LEN)) begin
                                n_rej   = ST_LONG;
                                n_state = S_INS_END;
                            end else begin
                                n_state = S_INS_RD;
                            end
                        end
                        OP_BUILD: begin
                            n_c = CNT_W'(1);
                            n_d = LEN_W'(1);
                            n_state = (r_node_count == CNT_W'(1)) ? S_BLD_END : S_BLD_RD;
                        end
                        OP_SCAN: begin
                            if (!r_built) begin
                                n_st    = ST_UNBUILT;
                                n_state = S_EMIT;
                            end else begin
                                n_pos   = r_pos + 1'b1;
                                n_s     = r_scan_node;
                                n_state = S_SCN_CH;
                            end
                        end
                        OP_CLEAR: begin
                            n_c = CNT_W'(1);
                            n_state = (r_node_count == CNT_W'(1)) ? S_CLR_END : S_CLR_RD;
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                ch_raddr = {r_ins_node, r_sym};
                n_state  = S_INS_CHK;
            end
            S_INS_CHK: begin
                ch_raddr = {r_ins_node, r_sym};
                if (ch_rdata == '0 && r_node_count >= CNT_W'(MAX_NODES)) begin
                    n_rej   = ST_FULL;
                    n_state = S_INS_END;
                end else begin
                    if (ch_rdata == '0) begin
                        // grow the trie by one node
                        ch_we        = 1'b1;
                        ch_wdata     = new_node;
                        nd_we        = 1'b1;
                        n_node_count = r_node_count + 1'b1;
                        if (r_max_depth < nd_wdata) begin
                            n_max_depth = nd_wdata;
                        end
                    end
                    np_we = (ch_rdata == '0) || r_last;
                    if (r_last) begin
                        n_pcount   = r_pcount + 1'b1;
                        n_ins_node = '0;
                        n_ins_len  = '0;
                    end else begin
                        n_ins_node = new_node;
                        n_ins_len  = r_ins_len + 1'b1;
                    end
                    n_st    = ST_OK;
                    n_state = S_EMIT;
                end
            end
            S_INS_END: begin
                n_st = r_rej;
                if (r_last) begin
                    n_ins_node = '0;
                    n_ins_len  = '0;
                    n_rej      = ST_OK;
                end
                n_state = S_EMIT;
            end
            S_BLD_RD: begin
                n_state = S_BLD_CHK;
            end
            S_BLD_CHK: begin
                fl_raddr = pa_rdata;
                if (nd_rdata != r_d) begin
                    if (bld_last_c) begin
                        if (bld_last_d) begin
                            n_state = S_BLD_END;
                        end else begin
                            n_d = r_d + 1'b1;
                            n_c = CNT_W'(1);
                            n_state = S_BLD_RD;
                        end
                    end else begin
                        n_c = r_c + 1'b1;
                        n_state = S_BLD_RD;
                    end
                end else begin
                    n_a = sy_rdata;
                    if (pa_rdata == '0) begin
                        n_f     = '0;
                        n_state = S_BLD_F;
                    end else begin
                        n_state = S_BLD_G;
                    end
                end
            end
            S_BLD_G: begin
                n_g      = fl_rdata;
                ch_raddr = {fl_rdata, r_a};
                n_state  = S_BLD_GCHK;
            end
            S_BLD_GCHK: begin
                ch_raddr = {r_g, r_a};
                fl_raddr = r_g;
                // walk failure links until a node has the child or the root is hit
                if (r_g != '0 && ch_rdata == '0) begin
                    n_state = S_BLD_G;
                end else begin
                    n_f     = ch_rdata;
                    n_state = S_BLD_F;
                end
            end
            S_BLD_F: begin
                n_state = S_BLD_W;
            end
            S_BLD_W: begin
                fl_we = 1'b1;
                ol_we = 1'b1;
                if (r_f == '0) begin
                    ol_wdata = '0;
                end else if (np_rdata != '0) begin
                    ol_wdata = r_f;
                end else begin
                    ol_wdata = ol_rdata;
                end
                if (bld_last_c) begin
                    if (bld_last_d) begin
                        n_state = S_BLD_END;
                    end else begin
                        n_d = r_d + 1'b1;
                        n_c = CNT_W'(1);
                        n_state = S_BLD_RD;
                    end
                end else begin
                    n_c = r_c + 1'b1;
                    n_state = S_BLD_RD;
                end
            end
            S_BLD_END: begin
                n_built     = 1'b1;
                n_scan_node = '0;
                n_pos       = '0;
                n_st        = ST_OK;
                n_state     = S_EMIT;
            end
            S_SCN_CH: begin
                n_state = S_SCN_CHK;
            end
            S_SCN_CHK: begin
                if (ch_rdata == '0 && r_s != '0) begin
                    n_state = S_SCN_F;
                end else begin
                    n_s     = ch_rdata;
                    n_state = S_SCN_N;
                end
            end
            S_SCN_F: begin
                n_s      = fl_rdata;
                ch_raddr = {fl_rdata, r_sym};
                n_state  = S_SCN_CHK;
            end
            S_SCN_N: begin
                np_raddr = r_s;
                ol_raddr = r_s;
                n_state  = S_SCN_N2;
            end
            S_SCN_N2: begin
                np_raddr = r_s;
                ol_raddr = r_s;
                if (r_s == '0) begin
                    n_n = '0;
                end else begin
                    n_n = (np_rdata != '0) ? r_s : ol_rdata;
                end
                n_k         = '0;
                n_scan_node = r_last ? '0 : r_s;
                n_state     = S_SCN_E;
            end
            S_SCN_E: begin
                np_raddr = r_n;
                ol_raddr = r_n;
                nd_raddr = r_n;
                if (r_n == '0) begin
                    if (r_last) begin
                        n_pos = '0;
                    end
                    n_st    = ST_OK;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_SCN_E2;
                end
            end
            S_SCN_E2: begin
                np_raddr = r_n;
                ol_raddr = r_n;
                nd_raddr = r_n;
                em_valid = 1'b1;
                em.status      = ST_OK;
                em.match_found = 1'b1;
                em.pattern_id  = 8'(np_rdata - 1'b1);
                em.start_pos   = 32'(r_pos - POS_W'(nd_rdata) + 1'b1);
                em.end_pos     = 32'(r_pos);
                em.last_result = fin;
                if (out_free) begin
                    if (fin) begin
                        if (r_last) begin
                            n_pos = '0;
                        end
                        n_state = S_IDLE;
                    end else begin
                        n_n     = ol_rdata;
                        n_k     = r_k + 1'b1;
                        n_state = S_SCN_E;
                    end
                end
            end
            S_CLR_RD: begin
                n_state = S_CLR_WR;
            end
            S_CLR_WR: begin
                // drop the single child entry that points at this node
                ch_we    = 1'b1;
                ch_waddr = {pa_rdata, sy_rdata};
                if (bld_last_c) begin
                    n_state = S_CLR_END;
                end else begin
                    n_c     = r_c + 1'b1;
                    n_state = S_CLR_RD;
                end
            end
            S_CLR_END: begin
                n_node_count = CNT_W'(1);
                n_pcount     = '0;
                n_ins_node   = '0;
                n_ins_len    = '0;
                n_rej        = ST_OK;
                n_max_depth  = '0;
                n_scan_node  = '0;
                n_pos        = '0;
                n_built      = 1'b0;
                n_st         = ST_OK;
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                em_valid       = 1'b1;
                em.status      = r_st;
                em.last_result = 1'b1;
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_WIPE;
            r_wipe       <= '0;
            r_node_count <= CNT_W'(1);
            r_pcount     <= '0;
            r_ins_node   <= '0;
            r_ins_len    <= '0;
            r_max_depth  <= '0;
            r_rej        <= ST_OK;
            r_scan_node  <= '0;
            r_pos        <= '0;
            r_built      <= 1'b0;
            r_ov         <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_wipe       <= n_wipe;
            r_node_count <= n_node_count;
            r_pcount     <= n_pcount;
            r_ins_node   <= n_ins_node;
            r_ins_len    <= n_ins_len;
            r_max_depth  <= n_max_depth;
            r_rej        <= n_rej;
            r_scan_node  <= n_scan_node;
            r_pos        <= n_pos;
            r_built      <= n_built;
            if (out_free) begin
                r_ov <= em_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym  <= n_sym;
        r_last <= n_last;
        r_a    <= n_a;
        r_c    <= n_c;
        r_d    <= n_d;
        r_st   <= n_st;
        r_s    <= n_s;
        r_n    <= n_n;
        r_g    <= n_g;
        r_f    <= n_f;
        r_k    <= n_k;
        if (out_free && em_valid) begin
            r_od <= em;
        end
    end

    assign o_res_valid = r_ov;
    assign o_res       = r_od;

    `ACM_ASSERT(a_node_count, r_node_count != '0 && r_node_count <= CNT_W'(MAX_NODES))
    `ACM_ASSERT(a_match_ok, (o_res_valid && o_res.match_found) |-> (o_res.status == ST_OK))
    `ACM_ASSERT_NEXT(a_wipe_hold, r_state == S_WIPE && r_wipe != '1, r_state == S_WIPE)
endmodule

FILE: rtl/aho_corasick_matcher.sv
// Multi-pattern matcher with insert, failure-link build, text scan and clear operations.
// One item is worked at a time by the back-end sequencer; a 2-entry command queue and an
// output register keep both handshakes moving while the sequencer walks the trie memories.
// Reset is synchronous, active low; after it the 32768-entry child table is wiped before the
// back end takes the first command from the queue.
module aho_corasick_matcher import acm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_item,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  logic      i_out_stall
);
    logic cmd_valid, cmd_pop;
    t_cmd cmd;

    acm_front u_front (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_item, .o_in_stall,
        .o_cmd_valid(cmd_valid), .o_cmd(cmd), .i_cmd_pop(cmd_pop));

    acm_back u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(cmd_valid), .i_cmd(cmd), .o_cmd_pop(cmd_pop),
        .o_res_valid(o_out_valid), .o_res(o_out_item), .i_res_stall(i_out_stall));
endmodule
